/* src/sabtb_pkg.sv */
`default_nettype none

package sabtb_pkg;

   localparam int DEFAULT_SETS      = 64;
   localparam int DEFAULT_WAYS      = 4;
   localparam int DEFAULT_TAG_WIDTH = 16;

   localparam int ADDR_W  = 64;
   localparam int FUNC_W  = 16;
   localparam int COUNT_W = 8;
   localparam int RET_W   = 8;

   // Address bits folded into the set remainder per cycle when SETS is not a power of two.
   localparam int DIGIT_W = 8;

   typedef enum logic {
      ACTION_LOOKUP,
      ACTION_UPDATE
   } action_type;

   typedef enum logic {
      KIND_BR,
      KIND_CALL
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_MISS,
      STATUS_HIT,
      STATUS_REFRESH,
      STATUS_INSTALL
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_APPLY
   } state_type;

   typedef struct packed {
      action_type         action;
      logic [ADDR_W-1:0]  address;
      kind_type           kind;
      logic [FUNC_W-1:0]  func_id;
      logic [COUNT_W-1:0] arg_count;
      logic [RET_W-1:0]   ret_type_code;
      logic [ADDR_W-1:0]  new_target;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] target_out;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  target;
      kind_type           kind;
      logic [FUNC_W-1:0]  func_id;
      logic [COUNT_W-1:0] arg_count;
      logic [RET_W-1:0]   ret_type;
   } pay_type;

endpackage

`default_nettype wire

/* src/sabtb_chan_if.sv */
`default_nettype none

interface sabtb_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (
      output valid,
      output payload,
      input  ready
   );

   modport sink (
      input  valid,
      input  payload,
      output ready
   );

endinterface

`default_nettype wire

/* src/sabtb_set_index.sv */
`default_nettype none

module sabtb_set_index #(
   parameter int SETS  = sabtb_pkg::DEFAULT_SETS,
   parameter int IDX_W = 6
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start_i,
   input  wire logic [sabtb_pkg::ADDR_W-1:0] address_i,
   output logic                             done_o,
   output logic [IDX_W-1:0]                 index_o
);

   import sabtb_pkg::*;

   localparam int SET_SHIFT = $clog2(SETS + 1) - 1;
   localparam bit POW2      = ((1 << SET_SHIFT) == SETS);

   if (POW2) begin : g_mask

      logic [IDX_W-1:0] idx_ff, idx_in;

      always_comb begin
         if (start_i) begin
            idx_in = IDX_W'(address_i & ADDR_W'(SETS - 1));
         end else begin
            idx_in = idx_ff;
         end
      end

      always_ff @(posedge clock) begin
         idx_ff <= idx_in;
      end

      assign done_o  = 1'b1;
      assign index_o = idx_ff;

   end else begin : g_div

      localparam int STEPS = ADDR_W / DIGIT_W;
      localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

      logic              busy_ff, busy_in;
      logic [CNT_W-1:0]  cnt_ff, cnt_in;
      logic [ADDR_W-1:0] addr_ff, addr_in;
      logic [IDX_W-1:0]  rem_ff, rem_in;
      logic [IDX_W-1:0]  rem_step;

      // Restoring remainder, most significant address bit first.
      always_comb begin
         logic [IDX_W:0]   part;
         logic [IDX_W-1:0] rem_v;
         rem_v = rem_ff;
         part  = '0;
         for (int b = 0; b < DIGIT_W; b++) begin
            part = {rem_v, addr_ff[ADDR_W-1-b]};
            if (part >= (IDX_W+1)'(SETS)) begin
               part = part - (IDX_W+1)'(SETS);
            end
            rem_v = part[IDX_W-1:0];
         end
         rem_step = rem_v;
      end

      always_comb begin
         busy_in = busy_ff;
         cnt_in  = cnt_ff;
         addr_in = addr_ff;
         rem_in  = rem_ff;
         if (start_i) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            addr_in = address_i;
            rem_in  = '0;
         end else if (busy_ff) begin
            busy_in = (cnt_ff != CNT_W'(STEPS - 1));
            cnt_in  = cnt_ff + CNT_W'(1);
            addr_in = addr_ff << DIGIT_W;
            rem_in  = rem_step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            busy_ff <= 1'b0;
         end else begin
            busy_ff <= busy_in;
         end
      end

      always_ff @(posedge clock) begin
         cnt_ff  <= cnt_in;
         addr_ff <= addr_in;
         rem_ff  <= rem_in;
      end

      assign done_o  = !busy_ff;
      assign index_o = rem_ff;

   end

endmodule

`default_nettype wire

/* src/sabtb_set_update.sv */
`default_nettype none

module sabtb_set_update #(
   parameter int WAYS      = sabtb_pkg::DEFAULT_WAYS,
   parameter int TAG_WIDTH = sabtb_pkg::DEFAULT_TAG_WIDTH,
   parameter int CTL_W     = 21
) (
   input  wire sabtb_pkg::req_type                  req_i,
   input  wire logic [((TAG_WIDTH > 0) ? TAG_WIDTH : 1)-1:0] tag_i,
   input  wire logic [WAYS-1:0][CTL_W-1:0]         ctl_row_i,
   input  wire sabtb_pkg::pay_type [WAYS-1:0]      pay_row_i,
   output logic [WAYS-1:0][CTL_W-1:0]              ctl_row_o,
   output sabtb_pkg::pay_type [WAYS-1:0]           pay_row_o,
   output sabtb_pkg::status_type                   status_o,
   output logic [sabtb_pkg::ADDR_W-1:0]            target_o
);

   import sabtb_pkg::*;

   localparam int TAG_W = (TAG_WIDTH > 0) ? TAG_WIDTH : 1;
   localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } ctl_way_type;

   ctl_way_type       cur [WAYS];
   logic [WAYS-1:0]   lk_match;
   logic [WAYS-1:0]   tg_match;
   logic [WAYS-1:0]   oldest;
   logic [WAY_W-1:0]  lk_sel, tg_sel, old_sel, sel;
   logic              is_update, lk_any, tg_any, install, touch;
   logic [AGE_W-1:0]  thr;
   pay_type           fresh;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         cur[w]      = ctl_way_type'(ctl_row_i[w]);
         tg_match[w] = cur[w].valid && (cur[w].tag == tag_i);
         if (req_i.kind == KIND_CALL) begin
            lk_match[w] = tg_match[w] && (pay_row_i[w].kind == req_i.kind)
                          && (pay_row_i[w].arg_count == req_i.arg_count)
                          && (pay_row_i[w].ret_type == req_i.ret_type_code);
         end else begin
            lk_match[w] = tg_match[w] && (pay_row_i[w].kind == req_i.kind)
                          && (pay_row_i[w].func_id == req_i.func_id);
         end
         oldest[w] = (cur[w].age == AGE_MAX);
      end
   end

   // Lowest-numbered way wins in each case.
   always_comb begin
      lk_sel  = '0;
      tg_sel  = '0;
      old_sel = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (lk_match[w]) begin
            lk_sel = WAY_W'(w);
         end
         if (tg_match[w]) begin
            tg_sel = WAY_W'(w);
         end
         if (oldest[w]) begin
            old_sel = WAY_W'(w);
         end
      end
   end

   // The ages of a set always include one at the oldest value, so the victim is that way.
   always_comb begin
      is_update = (req_i.action == ACTION_UPDATE);
      lk_any    = |lk_match;
      tg_any    = |tg_match;
      install   = is_update && !tg_any;
      touch     = is_update || lk_any;
      if (!is_update) begin
         sel = lk_sel;
      end else if (tg_any) begin
         sel = tg_sel;
      end else begin
         sel = old_sel;
      end
      thr = install ? AGE_MAX : cur[sel].age;

      fresh.target    = req_i.new_target;
      fresh.kind      = req_i.kind;
      fresh.func_id   = req_i.func_id;
      fresh.arg_count = req_i.arg_count;
      fresh.ret_type  = req_i.ret_type_code;
   end

   always_comb begin
      ctl_way_type nxt;
      nxt = '0;
      for (int w = 0; w < WAYS; w++) begin
         nxt = cur[w];
         if (touch && (cur[w].age < thr)) begin
            nxt.age = cur[w].age + AGE_W'(1);
         end
         if (touch && (WAY_W'(w) == sel)) begin
            nxt.age = '0;
            if (install) begin
               nxt.valid = 1'b1;
               nxt.tag   = tag_i;
            end
         end
         ctl_row_o[w] = nxt;
         if (is_update && (WAY_W'(w) == sel)) begin
            pay_row_o[w] = fresh;
         end else begin
            pay_row_o[w] = pay_row_i[w];
         end
      end
   end

   always_comb begin
      if (!is_update) begin
         status_o = lk_any ? STATUS_HIT : STATUS_MISS;
      end else begin
         status_o = tg_any ? STATUS_REFRESH : STATUS_INSTALL;
      end
      if (!is_update && lk_any) begin
         target_o = pay_row_i[sel].target;
      end else begin
         target_o = '0;
      end
   end

endmodule

`default_nettype wire

/* src/set_assoc_branch_target_buffer.sv */
// Set-associative branch target buffer with age-counter replacement.
// Requests arrive on req_chan and each produces exactly one response on rsp_chan,
// both valid/ready channels. A lookup returns hit or miss and the stored target;
// an update refreshes a way with the same tag or installs into the oldest way.
// Each set is held as one row in two single-port memories, one for valid, tag
// and age, the other for target and match fields; the block reads the row,
// updates it and writes it back.
// A request is taken, its set index is worked out, its row is read from both
// memories, and the row is compared and written back while the response is
// registered; the next request can be taken during that write-back. When SETS
// is a power of two the set index is a mask of the address; otherwise it is
// worked out eight address bits per cycle.
// After reset the block sweeps the control memory, one set per cycle, and takes
// no request until it finishes.
// A response waits in an output register while the receiver stalls; the next
// request is still taken and read, but is not completed until that slot frees.
`default_nettype none

module set_assoc_branch_target_buffer #(
   parameter int SETS      = sabtb_pkg::DEFAULT_SETS,
   parameter int WAYS      = sabtb_pkg::DEFAULT_WAYS,
   parameter int TAG_WIDTH = sabtb_pkg::DEFAULT_TAG_WIDTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   sabtb_chan_if.sink    req_chan,
   sabtb_chan_if.source  rsp_chan
);

   import sabtb_pkg::*;

   localparam int SET_SHIFT = $clog2(SETS + 1) - 1;
   localparam int IDX_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TAG_W     = (TAG_WIDTH > 0) ? TAG_WIDTH : 1;
   localparam int AGE_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CTL_W     = 1 + TAG_W + AGE_W;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } ctl_way_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           clr_ff, clr_in;
   req_type                    req_ff, req_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic                       out_free, accept, req_ready;
   logic                       rd_en, apply_en, clearing;
   logic                       idx_done;
   logic [IDX_W-1:0]           set_idx;
   logic [TAG_W-1:0]           req_tag;

   logic [WAYS-1:0][CTL_W-1:0] ctl_mem [SETS];
   logic [WAYS-1:0][CTL_W-1:0] ctl_rd_ff;
   logic [WAYS-1:0][CTL_W-1:0] ctl_new;
   logic [WAYS-1:0][CTL_W-1:0] ctl_wr_data;
   logic [WAYS-1:0][CTL_W-1:0] reset_row;
   logic [IDX_W-1:0]           ctl_wr_idx;
   logic                       ctl_wr_en;
   ctl_way_type                reset_way;

   pay_type [WAYS-1:0]         pay_mem [SETS];
   pay_type [WAYS-1:0]         pay_rd_ff;
   pay_type [WAYS-1:0]         pay_new;

   status_type                 upd_status;
   logic [ADDR_W-1:0]          upd_target;

   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign accept           = req_chan.valid && req_ready;
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   if (TAG_WIDTH > 0) begin : g_tag
      assign req_tag = req_ff.address[SET_SHIFT +: TAG_W];
   end else begin : g_no_tag
      assign req_tag = '0;
   end

   sabtb_set_index #(
      .SETS  (SETS),
      .IDX_W (IDX_W)
   ) u_set_index (
      .clock     (clock),
      .reset     (reset),
      .start_i   (accept),
      .address_i (req_chan.payload.address),
      .done_o    (idx_done),
      .index_o   (set_idx)
   );

   sabtb_set_update #(
      .WAYS      (WAYS),
      .TAG_WIDTH (TAG_WIDTH),
      .CTL_W     (CTL_W)
   ) u_set_update (
      .req_i     (req_ff),
      .tag_i     (req_tag),
      .ctl_row_i (ctl_rd_ff),
      .pay_row_i (pay_rd_ff),
      .ctl_row_o (ctl_new),
      .pay_row_o (pay_new),
      .status_o  (upd_status),
      .target_o  (upd_target)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            if (idx_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in = accept ? ST_INDEX : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      apply_en  = 1'b0;
      clearing  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_INDEX: begin
            rd_en = idx_done;
         end
         ST_APPLY: begin
            req_ready = out_free;
            apply_en  = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      clr_in       = clearing ? clr_ff + IDX_W'(1) : clr_ff;
      req_in       = accept ? req_chan.payload : req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (apply_en) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.status     = upd_status;
         rsp_data_in.target_out = upd_target;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      reset_way.valid = 1'b0;
      reset_way.tag   = '0;
      reset_way.age   = AGE_MAX;
      for (int w = 0; w < WAYS; w++) begin
         reset_row[w] = reset_way;
      end
      ctl_wr_en   = clearing || apply_en;
      ctl_wr_idx  = clearing ? clr_ff : set_idx;
      ctl_wr_data = clearing ? reset_row : ctl_new;
   end

   always_ff @(posedge clock) begin
      if (ctl_wr_en) begin
         ctl_mem[ctl_wr_idx] <= ctl_wr_data;
      end
      if (rd_en) begin
         ctl_rd_ff <= ctl_mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (apply_en) begin
         pay_mem[set_idx] <= pay_new;
      end
      if (rd_en) begin
         pay_rd_ff <= pay_mem[set_idx];
      end
   end

   a_no_request_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("Request taken during the control memory sweep.");

   a_row_read_before_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && $past(state_ff) != ST_APPLY) |-> $past(rd_en))
      else $error("Set row used without a preceding memory read.");

   a_no_response_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !apply_en)
      else $error("Pending response overwritten while the receiver stalls.");

   a_status_follows_action: assert property (@(posedge clock) disable iff (reset)
      apply_en |=> (rsp_data_ff.status[1] == $past(req_ff.action)))
      else $error("Response status does not match the request action.");

endmodule

`default_nettype wire
